[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

    // geometry
    localparam int NUM_PAGES = 1024;
    localparam int PG_W      = 10;
    localparam int LNK_W     = 11;
    localparam int MAX_ORDER = 10;
    localparam int ORD_W     = 4;
    localparam int REF_W     = 16;

    localparam logic [LNK_W-1:0] NIL     = LNK_W'(NUM_PAGES);
    localparam logic [REF_W-1:0] REF_MAX = '1;

    // commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOBLK  = 2'd1;
    localparam logic [1:0] ST_NOREF  = 2'd2;

    // one page record in the page table
    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic [REF_W-1:0] refc;
        logic             onfl;
        logic [LNK_W-1:0] nxt;
        logic [LNK_W-1:0] prv;
    } t_ent;

    localparam t_ent ENT_RST = '{order: '0, refc: '0, onfl: 1'b0, nxt: NIL, prv: NIL};

endpackage

[hw/rtl/buddy_page_allocator_top.sv]
// Channel   Ports                                              Handshake
// command   i_command i_page_index i_end_page i_order i_masked  start & !busy
// result    o_page_index_res o_status                           o_valid, one cycle
//
// Each command runs under a sequencer over one page table memory (one read and
// one write per cycle, registered read), built from unlink and push steps.
// Add: per chunk, step the order down to fit, then unlink and push (or mark).
// Allocate: up to MAX_ORDER head checks, an unlink, an unlink and push per split,
// then a record update. Free: a record update; on the last reference, buddy
// merges, then unlink and push. A bad command returns straight from idle.
// After reset a clearing pass over all NUM_PAGES (1024) pages holds busy high.
// The result strobe lasts one cycle; the receiver cannot stall it.
module buddy_page_allocator_top
    import bpa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic [PG_W-1:0]     i_page_index,
    input  logic [PG_W-1:0]     i_end_page,
    input  logic [ORD_W-1:0]    i_order,
    input  logic                i_masked,
    output logic                o_valid,
    output logic [PG_W-1:0]     o_page_index_res,
    output logic [1:0]          o_status
);

    // sequencer states
    localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,
                           S_UL   = 5'd2,  S_U0   = 5'd3,  S_U1 = 5'd4,
                           S_U2   = 5'd5,  S_U3   = 5'd6,  S_U4 = 5'd7,
                           S_P1   = 5'd8,  S_P2   = 5'd9,  S_P3 = 5'd10,
                           S_A0   = 5'd11, S_AM   = 5'd12, S_AN = 5'd13,
                           S_S0   = 5'd14, S_S1   = 5'd15, S_S2 = 5'd16,
                           S_S3   = 5'd17, S_F0   = 5'd18, S_F1 = 5'd19,
                           S_F2   = 5'd20, S_F3   = 5'd21, S_F4 = 5'd22,
                           S_F5   = 5'd23;

    logic [4:0]       r_st, n_st, r_uret, n_uret, r_pret, n_pret;
    logic [PG_W-1:0]  r_pg, n_pg, r_end, n_end, r_ca, n_ca, r_res, n_res;
    logic [ORD_W-1:0] r_po, n_po, r_o, n_o, r_want, n_want;
    logic             r_clr, n_clr, r_mask, n_mask, r_valid, n_valid;
    logic [LNK_W-1:0] r_pt, n_pt;
    logic [1:0]       r_stat, n_stat;
    t_ent             r_ent, n_ent;
    logic [LNK_W-1:0] r_head [MAX_ORDER];

    // head list update request
    logic             hd_we;
    logic [ORD_W-1:0] hd_idx;
    logic [LNK_W-1:0] hd_val;

    // page table memory
    t_ent             mem [NUM_PAGES];
    t_ent             r_rd, wdata;
    logic [PG_W-1:0]  raddr, waddr;
    logic             we;

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rd <= mem[raddr];
    end

    // shared adder / shifter terms
    logic [LNK_W-1:0] w_pow, w_last, w_up;
    logic [ORD_W-1:0] w_odec;
    logic [PG_W-1:0]  w_bud;
    logic [LNK_W-1:0] w_head;

    assign w_pow  = LNK_W'(1) << r_o;
    assign w_last = r_pt + w_pow - LNK_W'(1);
    assign w_odec = r_o - ORD_W'(1);
    assign w_up   = {1'b0, r_pt[PG_W-1:0]} + (LNK_W'(1) << w_odec);
    assign w_bud  = r_pt[PG_W-1:0] ^ (PG_W'(1) << r_o);
    assign w_head = r_head[r_po];

    always_comb begin
        n_st = r_st;  n_uret = r_uret; n_pret = r_pret;
        n_pg = r_pg;  n_end = r_end;   n_ca = r_ca;   n_res = r_res;
        n_po = r_po;  n_o = r_o;       n_want = r_want;
        n_clr = r_clr; n_mask = r_mask; n_valid = 1'b0;
        n_pt = r_pt;  n_stat = r_stat; n_ent = r_ent;
        hd_we = 1'b0; hd_idx = r_po;   hd_val = NIL;
        raddr = '0;   waddr = r_pg;    we = 1'b0;   wdata = r_ent;

        case (r_st)
            // clearing pass over the page table
            S_CLR: begin
                we = 1'b1; waddr = r_ca; wdata = ENT_RST;
                n_ca = r_ca + PG_W'(1);
                if (r_ca == PG_W'(NUM_PAGES - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_res = '0; n_stat = ST_OK;
                    case (i_command)
                        CMD_ADD: begin
                            n_pt = {1'b0, i_page_index}; n_end = i_end_page;
                            n_o = ORD_W'(MAX_ORDER - 1); n_mask = i_masked;
                            n_st = S_A0;
                        end
                        CMD_ALLOC: begin
                            if (i_order >= ORD_W'(MAX_ORDER)) begin
                                n_stat = ST_NOBLK; n_valid = 1'b1;
                            end else begin
                                n_want = i_order; n_o = i_order; n_st = S_S0;
                            end
                        end
                        CMD_FREE: begin
                            n_pt = {1'b0, i_page_index}; n_st = S_F0;
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            // unlink r_pg: load record
            S_UL: begin
                raddr = r_pg; n_st = S_U0;
            end
            S_U0: begin
                n_ent = r_rd;
                if (!r_rd.onfl) n_st = r_uret;
                else if (r_rd.nxt < NIL) begin
                    raddr = r_rd.nxt[PG_W-1:0]; n_st = S_U1;
                end else n_st = S_U2;
            end
            S_U1: begin
                we = 1'b1; waddr = r_ent.nxt[PG_W-1:0];
                wdata = r_rd; wdata.prv = r_ent.prv;
                n_st = S_U2;
            end
            S_U2: begin
                if (r_ent.prv < NIL) begin
                    raddr = r_ent.prv[PG_W-1:0]; n_st = S_U3;
                end else begin
                    hd_we = (r_ent.order < ORD_W'(MAX_ORDER));
                    hd_idx = r_ent.order; hd_val = r_ent.nxt;
                    n_st = S_U4;
                end
            end
            S_U3: begin
                we = 1'b1; waddr = r_ent.prv[PG_W-1:0];
                wdata = r_rd; wdata.nxt = r_ent.nxt;
                n_st = S_U4;
            end
            S_U4: begin
                n_ent.nxt = NIL; n_ent.prv = NIL; n_ent.onfl = 1'b0;
                we = 1'b1; wdata = n_ent;
                n_st = r_uret;
            end
            // push r_pg on list r_po (after unlink)
            S_P1: begin
                n_ent.order = r_po;
                if (r_clr) n_ent.refc = '0;
                if (w_head < NIL) begin
                    raddr = w_head[PG_W-1:0]; n_st = S_P2;
                end else n_st = S_P3;
            end
            S_P2: begin
                we = 1'b1; waddr = w_head[PG_W-1:0];
                wdata = r_rd; wdata.prv = {1'b0, r_pg};
                n_st = S_P3;
            end
            S_P3: begin
                n_ent.nxt = w_head; n_ent.prv = NIL; n_ent.onfl = 1'b1;
                we = 1'b1; wdata = n_ent;
                hd_we = 1'b1; hd_idx = r_po; hd_val = {1'b0, r_pg};
                n_st = r_pret;
            end
            // add range: shrink order, then place chunk
            S_A0: begin
                if (r_pt > {1'b0, r_end}) begin
                    n_valid = 1'b1; n_st = S_IDLE;
                end else if (r_o != '0 && w_last > {1'b0, r_end}) begin
                    n_o = w_odec;
                end else begin
                    n_pg = r_pt[PG_W-1:0];
                    if (r_mask) begin
                        n_uret = S_AM; n_st = S_UL;
                    end else begin
                        n_po = r_o; n_clr = 1'b1; n_pret = S_AN;
                        n_uret = S_P1; n_st = S_UL;
                    end
                end
            end
            S_AM: begin
                n_ent.refc = '0; n_ent.order = ORD_W'(MAX_ORDER);
                we = 1'b1; wdata = n_ent;
                n_st = S_AN;
            end
            S_AN: begin
                n_pt = r_pt + w_pow; n_st = S_A0;
            end
            // allocate: scan heads
            S_S0: begin
                if (r_head[r_o] < NIL) begin
                    n_pt = r_head[r_o]; n_pg = r_head[r_o][PG_W-1:0];
                    n_uret = S_S1; n_st = S_UL;
                end else if (r_o == ORD_W'(MAX_ORDER - 1)) begin
                    n_stat = ST_NOBLK; n_valid = 1'b1; n_st = S_IDLE;
                end else n_o = r_o + ORD_W'(1);
            end
            // split down, pushing upper halves
            S_S1: begin
                if (r_o > r_want) begin
                    n_o = w_odec;
                    if (w_up < NIL) begin
                        n_pg = w_up[PG_W-1:0]; n_po = w_odec; n_clr = 1'b1;
                        n_pret = S_S1; n_uret = S_P1; n_st = S_UL;
                    end
                end else n_st = S_S2;
            end
            S_S2: begin
                raddr = r_pt[PG_W-1:0]; n_st = S_S3;
            end
            S_S3: begin
                we = 1'b1; waddr = r_pt[PG_W-1:0]; wdata = r_rd;
                wdata.order = r_o;
                if (r_rd.refc != REF_MAX) wdata.refc = r_rd.refc + REF_W'(1);
                n_res = r_pt[PG_W-1:0]; n_valid = 1'b1; n_st = S_IDLE;
            end
            // free: drop reference
            S_F0: begin
                raddr = r_pt[PG_W-1:0]; n_st = S_F1;
            end
            S_F1: begin
                if (r_rd.refc == '0) begin
                    n_stat = ST_NOREF; n_valid = 1'b1; n_st = S_IDLE;
                end else begin
                    we = 1'b1; waddr = r_pt[PG_W-1:0]; wdata = r_rd;
                    wdata.refc = r_rd.refc - REF_W'(1);
                    n_o = (r_rd.order >= ORD_W'(MAX_ORDER)) ?
                          ORD_W'(MAX_ORDER - 1) : r_rd.order;
                    if (r_rd.refc != REF_W'(1)) begin
                        n_valid = 1'b1; n_st = S_IDLE;
                    end else n_st = S_F2;
                end
            end
            // merge with buddies
            S_F2: begin
                if (r_o < ORD_W'(MAX_ORDER - 1)) begin
                    raddr = w_bud; n_pg = w_bud; n_st = S_F3;
                end else n_st = S_F5;
            end
            S_F3: begin
                if (r_rd.onfl && r_rd.order == r_o && r_rd.refc == '0) begin
                    n_uret = S_F4; n_st = S_UL;
                end else n_st = S_F5;
            end
            S_F4: begin
                if (r_pg < r_pt[PG_W-1:0]) n_pt = {1'b0, r_pg};
                n_o = r_o + ORD_W'(1); n_st = S_F2;
            end
            S_F5: begin
                n_pg = r_pt[PG_W-1:0]; n_po = r_o; n_clr = 1'b0;
                n_pret = S_IDLE; n_uret = S_P1; n_st = S_UL;
                n_valid = 1'b0;
            end
            default: n_st = S_IDLE;
        endcase

        // the final push of a free ends the command
        if (r_st == S_P3 && r_pret == S_IDLE) n_valid = 1'b1;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_ca <= '0; r_valid <= 1'b0;
            r_res <= '0; r_stat <= ST_OK;
            for (int i = 0; i < MAX_ORDER; i++) r_head[i] <= NIL;
        end else begin
            r_st <= n_st; r_ca <= n_ca; r_valid <= n_valid;
            r_res <= n_res; r_stat <= n_stat;
            if (hd_we) r_head[hd_idx] <= hd_val;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_uret <= n_uret; r_pret <= n_pret; r_pg <= n_pg; r_end <= n_end;
        r_po <= n_po; r_o <= n_o; r_want <= n_want; r_clr <= n_clr;
        r_mask <= n_mask; r_pt <= n_pt; r_ent <= n_ent;
    end

    assign busy             = (r_st != S_IDLE);
    assign o_valid          = r_valid;
    assign o_page_index_res = r_res;
    assign o_status         = r_stat;

    // checks
    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_CLR |-> !o_valid) else $error("word during clearing pass");
    a_acc_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid) else $error("command dropped");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_page_index_res == '0)
        else $error("failed word carries a page");
    a_head_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head[0] <= NIL) else $error("list head out of range");

endmodule
